// ===== rtl/core/hbcd_pkg.sv =====
// Shared types, codes and helpers of the HTTP body chunk decoder.
package hbcd_pkg;

  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CountW   = 32;

  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_CHUNKED_MODE   = 2'd0,
    CFG_CONTENT_LENGTH = 2'd1,
    CFG_MAX_BODY       = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_BUSY  = 2'd0,
    ST_DONE  = 2'd1,
    ST_BAD   = 2'd2,
    ST_LARGE = 2'd3
  } status_t;

  typedef enum logic [6:0] {
    PH_SIZE     = 7'b0000001,
    PH_SIZE_LF  = 7'b0000010,
    PH_DATA     = 7'b0000100,
    PH_DATA_CR  = 7'b0001000,
    PH_DATA_LF  = 7'b0010000,
    PH_FINAL_CR = 7'b0100000,
    PH_FINAL_LF = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic                chunked_mode;
    logic [CountW-1:0]   content_length;
    logic [CountW-1:0]   max_body;
  } cfg_t;

  typedef struct packed {
    phase_t              phase;
    logic [CountW-1:0]   body_count;
    logic                digit_seen;
    status_t             status;
  } ctl_state_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    status_t    status;
  } result_t;

  // Bit 4 flags a hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/hbcd_in_if.sv =====
// Input channel of the decoder: one raw body byte per item.
interface hbcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// ===== rtl/core/hbcd_out_if.sv =====
// Result channel of the decoder: payload byte, its flag and the status.
interface hbcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       payload_valid;
  logic [1:0] status;

  modport source (output valid, output payload_byte, output payload_valid,
                  output status, input ready);
  modport sink (input valid, input payload_byte, input payload_valid,
                input status, output ready);
endinterface

// ===== rtl/core/hbcd_step.sv =====
// Next-state and result logic for one body byte.
module hbcd_step #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  hbcd_pkg::cfg_t       cfg,
  input  hbcd_pkg::ctl_state_t cur,
  input  logic [SIZE_BITS-1:0] chunk_left,
  input  logic [7:0]           data_byte,
  output hbcd_pkg::ctl_state_t nxt,
  output logic [SIZE_BITS-1:0] chunk_left_nxt,
  output hbcd_pkg::result_t    res
);
  import hbcd_pkg::*;

  logic [4:0] hex;
  logic       pass;

  always_comb begin
    hex            = hex_decode(data_byte);
    nxt            = cur;
    chunk_left_nxt = chunk_left;
    pass           = 1'b0;
    if (cur.status == ST_BUSY) begin
      if (!cfg.chunked_mode) begin
        if (cfg.max_body != '0 && cfg.content_length > cfg.max_body) begin
          nxt.status = ST_LARGE;
        end else if (cur.body_count < cfg.content_length) begin
          pass           = 1'b1;
          nxt.body_count = cur.body_count + 1'b1;
          if (nxt.body_count == cfg.content_length) begin
            nxt.status = ST_DONE;
          end
        end else begin
          nxt.status = ST_DONE;
        end
      end else begin
        case (cur.phase)
          PH_SIZE: begin
            if (data_byte == ChCr) begin
              if (!cur.digit_seen) nxt.status = ST_BAD;
              else nxt.phase = PH_SIZE_LF;
            end else if (!hex[4]) begin
              nxt.status = ST_BAD;
            end else if (chunk_left[SIZE_BITS-1 -: 4] != 4'd0) begin
              nxt.status = ST_LARGE;
            end else begin
              chunk_left_nxt = {chunk_left[SIZE_BITS-5:0], hex[3:0]};
              nxt.digit_seen = 1'b1;
            end
          end
          PH_SIZE_LF: begin
            if (data_byte != ChLf) nxt.status = ST_BAD;
            else if (chunk_left == '0) nxt.phase = PH_FINAL_CR;
            else nxt.phase = PH_DATA;
          end
          PH_DATA: begin
            if (cfg.max_body != '0 && cur.body_count >= cfg.max_body) begin
              nxt.status = ST_LARGE;
            end else begin
              pass = 1'b1;
              if (cur.body_count != '1) nxt.body_count = cur.body_count + 1'b1;
              chunk_left_nxt = chunk_left - 1'b1;
              if (chunk_left_nxt == '0) nxt.phase = PH_DATA_CR;
            end
          end
          PH_DATA_CR: begin
            if (data_byte != ChCr) nxt.status = ST_BAD;
            else nxt.phase = PH_DATA_LF;
          end
          PH_DATA_LF: begin
            if (data_byte != ChLf) begin
              nxt.status = ST_BAD;
            end else begin
              nxt.phase      = PH_SIZE;
              chunk_left_nxt = '0;
              nxt.digit_seen = 1'b0;
            end
          end
          PH_FINAL_CR: begin
            if (data_byte != ChCr) nxt.status = ST_BAD;
            else nxt.phase = PH_FINAL_LF;
          end
          PH_FINAL_LF: begin
            nxt.status = (data_byte == ChLf) ? ST_DONE : ST_BAD;
          end
          default: begin
            nxt.status = ST_BAD;
          end
        endcase
      end
    end
    res.payload_byte  = pass ? data_byte : 8'd0;
    res.payload_valid = pass;
    res.status        = nxt.status;
  end

endmodule

// ===== rtl/core/hbcd_out_buf.sv =====
// Result register with a skid entry, so the input side keeps going under a stall.
module hbcd_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hbcd_pkg::result_t  push_data,
  output logic               can_push,
  hbcd_out_if.source         out_ch
);
  import hbcd_pkg::*;

  logic    o_valid_r, o_valid_nxt;
  logic    s_valid_r, s_valid_nxt;
  result_t o_data_r, o_data_nxt;
  result_t s_data_r, s_data_nxt;

  assign can_push = !s_valid_r;

  always_comb begin
    o_valid_nxt = o_valid_r;
    o_data_nxt  = o_data_r;
    s_valid_nxt = s_valid_r;
    s_data_nxt  = s_data_r;
    if (!o_valid_r || out_ch.ready) begin
      if (s_valid_r) begin
        // drain the skid entry first; no push can arrive while it is full
        o_valid_nxt = 1'b1;
        o_data_nxt  = s_data_r;
        s_valid_nxt = 1'b0;
      end else begin
        o_valid_nxt = push;
        o_data_nxt  = push_data;
      end
    end else if (push) begin
      s_valid_nxt = 1'b1;
      s_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
      s_valid_r <= 1'b0;
    end else begin
      o_valid_r <= o_valid_nxt;
      s_valid_r <= s_valid_nxt;
    end
    o_data_r <= o_data_nxt;
    s_data_r <= s_data_nxt;
  end

  assign out_ch.valid         = o_valid_r;
  assign out_ch.payload_byte  = o_data_r.payload_byte;
  assign out_ch.payload_valid = o_data_r.payload_valid;
  assign out_ch.status        = o_data_r.status;

endmodule

// ===== rtl/core/http_body_chunk_decoder.sv =====
// Top level of the HTTP body decoder: fixed-length and chunked body framing.
//
//   channel  | dir | payload                                  | handshake
//   ---------+-----+------------------------------------------+-------------
//   in_ch    | in  | data_byte[7:0]                           | valid/ready
//   out_ch   | out | payload_byte[7:0], payload_valid, status | valid/ready
//   cfg_*    | in  | cfg_addr[1:0], cfg_wdata[31:0]           | cfg_we only
//
// One byte is taken per cycle while in_ch.ready is high; its result is
// registered. The byte's state update is a single pass through hbcd_step.
// Reset (rst_n low at a clock edge) clears the framing state, the status
// and the configuration registers. A stalled result goes into a skid entry,
// so one more byte is taken under a stall; then in_ch.ready drops until the
// skid entry drains.
module http_body_chunk_decoder #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [hbcd_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [hbcd_pkg::CfgDataW-1:0] cfg_wdata,
  hbcd_in_if.sink                       in_ch,
  hbcd_out_if.source                    out_ch
);
  import hbcd_pkg::*;

  cfg_t                 cfg_r;
  ctl_state_t           st_r, st_nxt;
  logic [SIZE_BITS-1:0] chunk_left_r, chunk_left_nxt;
  result_t              res;
  logic                 can_push;
  logic                 accept;

  assign in_ch.ready = can_push;
  assign accept      = in_ch.valid && can_push;

  // Configuration: take a write at once; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_CHUNKED_MODE:   cfg_r.chunked_mode   <= cfg_wdata[0];
        CFG_CONTENT_LENGTH: cfg_r.content_length <= cfg_wdata[CountW-1:0];
        CFG_MAX_BODY:       cfg_r.max_body       <= cfg_wdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  hbcd_step #(
    .SIZE_BITS (SIZE_BITS)
  ) u_step (
    .cfg            (cfg_r),
    .cur            (st_r),
    .chunk_left     (chunk_left_r),
    .data_byte      (in_ch.data_byte),
    .nxt            (st_nxt),
    .chunk_left_nxt (chunk_left_nxt),
    .res            (res)
  );

  // Framing state: advance only on an accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase      <= PH_SIZE;
      st_r.body_count <= '0;
      st_r.digit_seen <= 1'b0;
      st_r.status     <= ST_BUSY;
      chunk_left_r    <= '0;
    end else if (accept) begin
      st_r         <= st_nxt;
      chunk_left_r <= chunk_left_nxt;
    end
  end

  hbcd_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .can_push  (can_push),
    .out_ch    (out_ch)
  );

endmodule
